@@ rtl/fsa_pkg.sv @@
package fsa_pkg;

    localparam int SLOTS        = 4096;
    localparam int HEADER_BYTES = 16;

    localparam int SLOT_W   = 12;
    localparam int COUNT_W  = 13;
    localparam int OFFSET_W = 28;
    localparam int STRIDE_W = 16;
    localparam int LIMIT_W  = 13;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    localparam int SLOT_SPAN = 1 << SLOT_W;
    localparam int ISSUE_MAX = (SLOTS < SLOT_SPAN) ? SLOTS : SLOT_SPAN;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(64);
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(4096);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [1:0] STATUS_BAD_FREE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SLOT_STRIDE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_LIMIT  = 1'b1;

    typedef struct packed {
        logic              command;
        logic [SLOT_W-1:0] free_slot;
    } fsa_in_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [OFFSET_W-1:0] byte_offset;
        logic [1:0]          status;
    } fsa_out_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic mul;
        logic load;
    } fsa_cmd_t;

    typedef struct packed {
        logic out_busy;
    } fsa_stat_t;

endpackage

@@ rtl/fixed_slot_allocator.sv @@
// Fixed-size slot allocator with a LIFO free list and a bump counter.
// Input channel (in_valid/in_ready/in_data) carries one command per transfer:
// allocate pops the most recently freed slot, or issues the next unused slot;
// free pushes free_slot back onto the list if it is below the bump counter.
// Output channel (out_valid/out_ready/out_data) returns one result per
// command: slot, byte_offset = slot * slot_stride + header, and status.
// An accepted command passes decide and link read, multiply and result load
// before out_valid. A new command is taken only in the first state of the
// controller's four-state sequence: accept, decide and link read, multiply, load.
// A finished result sits in the output register; a new command is taken
// while it waits, but the next result cannot load until it is transferred,
// so a stalled receiver holds the controller in its final state.
// Reset empties the free list, clears the bump counter and restores
// slot_stride to 64 and slot_limit to 4096. The link memory needs no clearing.
// Configuration: cfg_we with cfg_index and cfg_data, written while idle.
module fixed_slot_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  fsa_pkg::fsa_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output fsa_pkg::fsa_out_t              out_data,
    input  logic                           cfg_we,
    input  logic [fsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsa_pkg::CFG_W-1:0]      cfg_data
);
    import fsa_pkg::*;

    fsa_cmd_t  cmd;
    fsa_stat_t stat;

    fsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fsa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

@@ rtl/fsa_ctrl.sv @@
module fsa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fsa_pkg::fsa_stat_t stat,
    output fsa_pkg::fsa_cmd_t  cmd
);
    import fsa_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready    = (state_reg == ST_IDLE);
    assign cmd.capture = in_valid && in_ready;
    assign cmd.exec    = (state_reg == ST_EXEC);
    assign cmd.mul     = (state_reg == ST_MUL);
    assign cmd.load    = (state_reg == ST_DONE) && !stat.out_busy;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: state_next = ST_MUL;
            ST_MUL:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/fsa_datapath.sv @@
module fsa_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fsa_pkg::fsa_cmd_t              cmd,
    output fsa_pkg::fsa_stat_t             stat,
    input  fsa_pkg::fsa_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output fsa_pkg::fsa_out_t              out_data,
    input  logic                           cfg_we,
    input  logic [fsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsa_pkg::CFG_W-1:0]      cfg_data
);
    import fsa_pkg::*;

    localparam logic [COUNT_W-1:0] EMPTY_MARK = COUNT_W'(SLOTS);
    localparam logic [COUNT_W-1:0] CAP_MAX    = COUNT_W'(ISSUE_MAX);

    logic [COUNT_W-1:0] next_link [SLOTS];

    logic [STRIDE_W-1:0] stride_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [COUNT_W-1:0]  head_reg;
    logic [COUNT_W-1:0]  issued_reg;
    logic [COUNT_W-1:0]  rdata_reg;
    logic                op_reg;
    logic [SLOT_W-1:0]   fslot_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                ok_reg;
    logic                pop_reg;
    logic [1:0]          status_reg;
    logic [OFFSET_W-1:0] product_reg;
    fsa_out_t            out_reg;
    logic                out_valid_reg;

    logic [COUNT_W-1:0]  cap;
    logic                list_nonempty;
    logic                can_bump;
    logic                free_legal;
    logic                push_en;

    assign cap           = (COUNT_W'(limit_reg) > CAP_MAX) ? CAP_MAX : COUNT_W'(limit_reg);
    assign list_nonempty = head_reg < EMPTY_MARK;
    assign can_bump      = issued_reg < cap;
    assign free_legal    = (COUNT_W'(fslot_reg) < issued_reg)
                        && (COUNT_W'(fslot_reg) < EMPTY_MARK);
    assign push_en       = cmd.exec && (op_reg == CMD_FREE) && free_legal;

    assign out_valid     = out_valid_reg;
    assign out_data      = out_reg;
    assign stat.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            next_link[fslot_reg] <= head_reg;
        end
        rdata_reg <= next_link[head_reg[SLOT_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= STRIDE_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SLOT_STRIDE: stride_reg <= cfg_data;
                REG_SLOT_LIMIT:  limit_reg  <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= EMPTY_MARK;
            issued_reg    <= '0;
            pop_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                pop_reg <= (op_reg == CMD_ALLOC) && list_nonempty;
                if ((op_reg == CMD_ALLOC) && !list_nonempty && can_bump)
                begin
                    issued_reg <= issued_reg + COUNT_W'(1);
                end
                if (push_en)
                begin
                    head_reg <= COUNT_W'(fslot_reg);
                end
            end
            if (cmd.mul && pop_reg)
            begin
                head_reg <= rdata_reg;
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= in_data.command;
            fslot_reg <= in_data.free_slot;
        end
        if (cmd.exec)
        begin
            if (op_reg == CMD_ALLOC)
            begin
                if (list_nonempty)
                begin
                    slot_reg   <= head_reg[SLOT_W-1:0];
                    ok_reg     <= 1'b1;
                    status_reg <= STATUS_OK;
                end
                else if (can_bump)
                begin
                    slot_reg   <= issued_reg[SLOT_W-1:0];
                    ok_reg     <= 1'b1;
                    status_reg <= STATUS_OK;
                end
                else
                begin
                    slot_reg   <= '0;
                    ok_reg     <= 1'b0;
                    status_reg <= STATUS_EXHAUSTED;
                end
            end
            else
            begin
                slot_reg   <= '0;
                ok_reg     <= 1'b0;
                status_reg <= free_legal ? STATUS_OK : STATUS_BAD_FREE;
            end
        end
        if (cmd.mul)
        begin
            product_reg <= OFFSET_W'(slot_reg) * OFFSET_W'(stride_reg);
        end
        if (cmd.load)
        begin
            out_reg.slot        <= ok_reg ? slot_reg : '0;
            out_reg.byte_offset <= ok_reg ? product_reg + OFFSET_W'(HEADER_BYTES) : '0;
            out_reg.status      <= status_reg;
        end
    end

    a_issued_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        issued_reg <= EMPTY_MARK)
        else $error("bump counter beyond slot count");

    a_issued_step: assert property (@(posedge clk) disable iff (!rst_n)
        (issued_reg == $past(issued_reg)) || (issued_reg == $past(issued_reg) + COUNT_W'(1)))
        else $error("bump counter moved by more than one");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.status != STATUS_OK)
        |-> (out_reg.slot == '0) && (out_reg.byte_offset == '0))
        else $error("failed result carries nonzero slot or offset");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !(out_valid_reg && !out_ready))
        else $error("result register overwritten while stalled");

endmodule
